### rtl/isxa_pkg.sv
// Shared types and constants for the italic skeleton x adjustment block.
// No dependencies; every other file imports this package.
package isxa_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned YO_W      = 14;
  localparam int unsigned DIFF_W    = 18;
  localparam int unsigned PROD_W    = 34;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned MUL_A_W   = 17;
  localparam int unsigned MUL_P_W   = 33;
  localparam int unsigned ACC_W     = 31;
  localparam int unsigned SLANT_SH  = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_CYC   = 16;
  localparam int unsigned DIV_CNT_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ANGLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_LOCAL  = 2'd2;

  localparam logic REQ_SEG   = 1'b0;
  localparam logic REQ_POINT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIV0,
    ST_DIV,
    ST_MAP,
    ST_MULA,
    ST_MULB,
    ST_OUT
  } isxa_state_t;

  typedef struct packed {
    logic seg_push;
    logic pt_load;
    logic prod_load;
    logic div_start;
    logic map_y;
    logic mul_a;
    logic mul_b;
    logic out_load;
  } isxa_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
    logic out_free;
  } isxa_sts_t;

endpackage

### rtl/isxa_in_if.sv
// Input channel: valid/ready handshake with segment and point payload.
// Depends on isxa_pkg.
interface isxa_in_if import isxa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [COORD_W-1:0] y_original;
  logic signed [COORD_W-1:0] y_adjusted;
  logic        [COORD_W-1:0] contour_y;
  logic signed [COORD_W-1:0] x_intermediate;

  modport source (output valid, req_type, y_original, y_adjusted, contour_y,
                  x_intermediate, input ready);
  modport sink   (input valid, req_type, y_original, y_adjusted, contour_y,
                  x_intermediate, output ready);
endinterface

### rtl/isxa_out_if.sv
// Result channel: valid/ready handshake carrying the adjusted x.
// Depends on isxa_pkg.
interface isxa_out_if import isxa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_adjusted;

  modport source (output valid, x_adjusted, input ready);
  modport sink   (input valid, x_adjusted, output ready);
endinterface

### rtl/isxa_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on isxa_pkg.
interface isxa_cfg_if import isxa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [COORD_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### rtl/isxa_div.sv
// Iterative signed divider, two quotient bits per cycle, truncating.
// Returns the low 16 bits of the quotient. Depends on isxa_pkg.
module isxa_div import isxa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [PROD_W-1:0]  dvd,
  input  logic signed [COORD_W-1:0] dvs,
  output logic        [COORD_W-1:0] quo,
  output logic                      done
);

  logic [COORD_W-1:0]   rem_r, rem_nxt;
  logic [MAG_W-1:0]     q_r, q_nxt;
  logic [COORD_W-1:0]   d_r, d_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 neg_r, neg_nxt;
  logic [PROD_W-1:0]    dvd_abs;
  logic [COORD_W-1:0]   dvs_abs;
  logic [COORD_W+MAG_W-1:0] s1, s2;

  function automatic logic [COORD_W+MAG_W-1:0] div_step(
    input logic [COORD_W-1:0] rem,
    input logic [MAG_W-1:0]   q,
    input logic [COORD_W-1:0] d
  );
    logic [COORD_W:0] t;
    logic             qb;
    t  = {rem, q[MAG_W-1]};
    qb = 1'b0;
    if (t >= {1'b0, d}) begin
      t  = t - {1'b0, d};
      qb = 1'b1;
    end
    return {t[COORD_W-1:0], q[MAG_W-2:0], qb};
  endfunction

  assign dvd_abs = dvd[PROD_W-1] ? PROD_W'(-dvd) : PROD_W'(dvd);
  assign dvs_abs = dvs[COORD_W-1] ? COORD_W'(-dvs) : COORD_W'(dvs);
  assign s1 = div_step(rem_r, q_r, d_r);
  assign s2 = div_step(s1[COORD_W+MAG_W-1:MAG_W], s1[MAG_W-1:0], d_r);

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dvd_abs[MAG_W-1:0];
      d_nxt    = dvs_abs;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      neg_nxt  = dvd[PROD_W-1] ^ dvs[COORD_W-1];
    end else if (busy_r) begin
      rem_nxt = s2[COORD_W+MAG_W-1:MAG_W];
      q_nxt   = s2[MAG_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_CYC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign quo  = neg_r ? COORD_W'(-q_r[COORD_W-1:0]) : q_r[COORD_W-1:0];
  assign done = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##17 done_r) else $error("divider latency wrong");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");

endmodule

### rtl/isxa_dp.sv
// Datapath: configuration and segment registers, y mapping, slant multiply,
// output register. Depends on isxa_pkg and isxa_div.
module isxa_dp import isxa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  isxa_cmd_t                 cmd,
  output isxa_sts_t                 sts,
  input  logic signed [COORD_W-1:0] in_y_original,
  input  logic signed [COORD_W-1:0] in_y_adjusted,
  input  logic        [COORD_W-1:0] in_contour_y,
  input  logic signed [COORD_W-1:0] in_x_intermediate,
  input  logic                      cfg_valid,
  input  logic        [CFG_IDX_W-1:0] cfg_reg_index,
  input  logic        [COORD_W-1:0] cfg_wdata,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_x_adjusted
);

  logic signed [COORD_W-1:0] global_angle_r, local_angle_r;
  logic                      force_local_r;
  logic signed [COORD_W-1:0] seg_so_r, seg_sa_r, seg_eo_r, seg_ea_r;
  logic        [YO_W-1:0]    yo_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [COORD_W-1:0] num_r, den_r;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [COORD_W-1:0] yn_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0] x_adj_r;
  logic        [COORD_W-1:0] quo;
  logic                      use_global;
  logic signed [MUL_A_W-1:0] mul_a_op;
  logic signed [COORD_W-1:0] mul_b_op;
  logic signed [MUL_P_W-1:0] mul_p;

  isxa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .dvd   (prod_r),
    .dvs   (den_r),
    .quo   (quo),
    .done  (sts.div_done)
  );

  assign use_global = (global_angle_r != '0) && !force_local_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_angle_r <= '0;
      local_angle_r  <= '0;
      force_local_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_index)
        REG_GLOBAL_ANGLE: global_angle_r <= cfg_wdata;
        REG_LOCAL_ANGLE:  local_angle_r  <= cfg_wdata;
        REG_FORCE_LOCAL:  force_local_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_so_r <= '0;
      seg_sa_r <= '0;
      seg_eo_r <= '0;
      seg_ea_r <= '0;
    end else if (cmd.seg_push) begin
      seg_so_r <= seg_eo_r;
      seg_sa_r <= seg_ea_r;
      seg_eo_r <= in_y_original;
      seg_ea_r <= in_y_adjusted;
    end
  end

  // slant multiplier operands: one 17x16 multiply per step
  always_comb begin
    if (cmd.mul_b) begin
      mul_a_op = {3'b000, yo_r};
      mul_b_op = local_angle_r;
    end else if (use_global) begin
      mul_a_op = {yn_r[COORD_W-1], yn_r};
      mul_b_op = global_angle_r;
    end else begin
      mul_a_op = {yn_r[COORD_W-1], yn_r} - {3'b000, yo_r};
      mul_b_op = local_angle_r;
    end
  end

  assign mul_p    = MUL_P_W'(mul_a_op) * MUL_P_W'(mul_b_op);
  assign prod_nxt = PROD_W'(diff_r) * PROD_W'(num_r);

  always_ff @(posedge clk) begin
    if (cmd.pt_load) begin
      yo_r   <= in_contour_y[YO_W-1:0];
      x_r    <= in_x_intermediate;
      diff_r <= $signed({{(DIFF_W-YO_W){1'b0}}, in_contour_y[YO_W-1:0]})
                - {{(DIFF_W-COORD_W){seg_so_r[COORD_W-1]}}, seg_so_r};
      num_r  <= seg_ea_r - seg_sa_r;
      den_r  <= seg_eo_r - seg_so_r;
    end
    if (cmd.prod_load) begin
      prod_r <= prod_nxt;
    end
    if (cmd.map_y) begin
      yn_r <= sts.den_zero ? diff_r[COORD_W-1:0] + seg_sa_r : $signed(quo) + seg_sa_r;
    end
    if (cmd.mul_a) begin
      acc_r <= mul_p[ACC_W-1:0];
    end else if (cmd.mul_b && use_global) begin
      acc_r <= acc_r - mul_p[ACC_W-1:0];
    end
    if (cmd.out_load) begin
      x_adj_r <= x_r + acc_r[SLANT_SH+COORD_W-1:SLANT_SH];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.den_zero  = (den_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_x_adjusted = x_adj_r;

endmodule

### rtl/isxa_ctrl.sv
// Controller state machine: takes segment beats in idle and sequences a point
// beat through product, divide (skipped for a zero span), mapping, slant multiply and output. Depends on isxa_pkg.
module isxa_ctrl import isxa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_req_type,
  output logic      in_ready,
  output isxa_cmd_t cmd,
  input  isxa_sts_t sts
);

  isxa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_SEG) begin
            cmd.seg_push = 1'b1;
          end else begin
            cmd.pt_load = 1'b1;
            state_nxt   = ST_PROD;
          end
        end
      end
      ST_PROD: begin
        cmd.prod_load = 1'b1;
        state_nxt     = ST_DIV0;
      end
      ST_DIV0: begin
        if (sts.den_zero) begin
          state_nxt = ST_MAP;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map_y = 1'b1;
        state_nxt = ST_MULA;
      end
      ST_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = ST_MULB;
      end
      ST_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/italic_skeleton_x_adjust.sv
// Italic skeleton x adjustment: a segment beat (req_type 0) shifts a new y
// pair into the skeleton segment and leaves the block ready. A point beat
// (req_type 1) yields one result, and no further beat is taken until it is in
// the output register; when the segment's original span is non-zero the
// result goes through the divider, which retires two quotient bits per cycle,
// and when the span is zero the divide is skipped. A finished result waits in
// the output register, so the next beat is taken while it is still pending. Configuration writes are always taken.
// Depends on isxa_pkg, the channel interfaces, isxa_ctrl and isxa_dp.
module italic_skeleton_x_adjust import isxa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  isxa_in_if.sink           in_ch,
  isxa_out_if.source        out_ch,
  isxa_cfg_if.sink          cfg_ch
);

  isxa_cmd_t cmd;
  isxa_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  isxa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  isxa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_y_original     (in_ch.y_original),
    .in_y_adjusted     (in_ch.y_adjusted),
    .in_contour_y      (in_ch.contour_y),
    .in_x_intermediate (in_ch.x_intermediate),
    .cfg_valid         (cfg_ch.valid),
    .cfg_reg_index     (cfg_ch.reg_index),
    .cfg_wdata         (cfg_ch.wdata),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_x_adjusted    (out_ch.x_adjusted)
  );

endmodule
